// ===== rtl/core/decimating_fir_filter_core_defines.svh =====
// Assertion macros for the decimating FIR filter core.
// Used by the port-level checker; expects clk and rst in scope.
`ifndef DECIMATING_FIR_FILTER_CORE_DEFINES_SVH
`define DECIMATING_FIR_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DFIR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DFIR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication that is also checked across reset.
`define DFIR_ASSERT_ALW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/dfir_pkg.sv =====
// Shared types and constants for the decimating FIR filter core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dfir_pkg;

  localparam int MAX_TAPS = 64;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int TAP_AW   = $clog2(MAX_TAPS);
  localparam int CNT_W    = TAP_AW + 1;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + TAP_AW;

  // Stream payload layout.
  localparam int RE_LSB     = 0;
  localparam int IM_LSB     = RE_LSB + SAMPLE_W;
  localparam int IDX_LSB    = IM_LSB + SAMPLE_W;
  localparam int VAL_LSB    = IDX_LSB + TAP_AW;
  localparam int IN_BITS    = VAL_LSB + COEF_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 2 * SAMPLE_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_NUM_TAPS   = 2'd0;
  localparam cfg_idx_t REG_DECIMATION = 2'd1;
  localparam cfg_idx_t REG_COMPLEX    = 2'd2;

  localparam logic [CFG_DATA_W-1:0] NUM_TAPS_RST   = CFG_DATA_W'(MAX_TAPS);
  localparam logic [CFG_DATA_W-1:0] DECIMATION_RST = CFG_DATA_W'(1);

  // Item kinds carried on s_tuser.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] im;
    logic signed [SAMPLE_W-1:0] re;
  } cpx_t;

  // Tag that travels with each tap read into the multiply-accumulate pipe.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic zero;
  } mac_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_HOLD
  } ctrl_state_t;

endpackage

// ===== rtl/core/decimating_fir_filter_core.sv =====
// Top level of the decimating FIR filter core: configuration registers and wiring.
// Depends on dfir_pkg, dfir_store, dfir_mac and dfir_ctrl.
//
//   Channel   Direction  Handshake           Payload
//   s_*       in         s_tvalid/s_tready   s_tdata (sample or coefficient), s_tuser (op)
//   m_*       out        m_tvalid/m_tready   m_tdata (filtered sample)
//   cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A coefficient write or a skipped sample is taken in ST_IDLE, which the sequencer
// does not leave. A sample that yields an output is accepted, then its taps pass
// one per cycle through the shared multiply-accumulate, the pipe drains through the
// registered memory read, the product register, the accumulator and the saturation
// register, and the result moves into the output register.
// Reset clears the sample history through a fill count; no clearing pass is needed.
// A finished result waits in the output register while the next item is taken;
// only the next result stalls if that register has not been emptied.
`timescale 1ns / 1ps

module decimating_fir_filter_core
  import dfir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] sample_re, [31:16] sample_im, [37:32] coef_index, [53:38] coef_value,
  // [55:54] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] op
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] result_re, [31:16] result_im
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0]   num_taps;
  logic [CFG_DATA_W-1:0]   decimation;
  logic                    complex_mode;
  logic [CNT_W-1:0]        taps_eff;
  logic [CNT_W-1:0]        dec_eff;
  logic [TAP_AW-1:0]       skip_load;

  logic                    tap_we;
  logic [TAP_AW-1:0]       tap_waddr;
  logic signed [COEF_W-1:0] tap_wdata;
  logic [TAP_AW-1:0]       tap_raddr;
  logic signed [COEF_W-1:0] tap_rdata;
  logic                    dly_we;
  logic [TAP_AW-1:0]       dly_waddr;
  cpx_t                    dly_wdata;
  logic [TAP_AW-1:0]       dly_raddr;
  cpx_t                    dly_rdata;
  mac_tag_t                tag;
  logic                    mac_done;
  cpx_t                    mac_res;

  // The configuration port never stalls; writes must come only while the core is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_taps     <= NUM_TAPS_RST;
      decimation   <= DECIMATION_RST;
      complex_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_TAPS:   num_taps     <= cfg_data;
        REG_DECIMATION: decimation   <= cfg_data;
        REG_COMPLEX:    complex_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // A tap count of zero acts as one tap and anything above the memory depth as
  // the full depth. The decimation is at least one and at most the tap count.
  always_comb begin
    if (num_taps == '0) begin
      taps_eff = CNT_W'(1);
    end else if (num_taps > CFG_DATA_W'(MAX_TAPS)) begin
      taps_eff = CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = num_taps;
    end
    if (decimation == '0) begin
      dec_eff = CNT_W'(1);
    end else if (decimation > taps_eff) begin
      dec_eff = taps_eff;
    end else begin
      dec_eff = decimation;
    end
  end

  // Samples to skip after each produced output.
  assign skip_load = TAP_AW'(dec_eff - CNT_W'(1));

  dfir_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .taps_eff     (taps_eff),
    .skip_load    (skip_load),
    .complex_mode (complex_mode),
    .tap_we       (tap_we),
    .tap_waddr    (tap_waddr),
    .tap_wdata    (tap_wdata),
    .tap_raddr    (tap_raddr),
    .dly_we       (dly_we),
    .dly_waddr    (dly_waddr),
    .dly_wdata    (dly_wdata),
    .dly_raddr    (dly_raddr),
    .tag          (tag),
    .mac_done     (mac_done),
    .mac_res      (mac_res)
  );

  dfir_store u_store (
    .clk       (clk),
    .tap_we    (tap_we),
    .tap_waddr (tap_waddr),
    .tap_wdata (tap_wdata),
    .tap_raddr (tap_raddr),
    .tap_rdata (tap_rdata),
    .dly_we    (dly_we),
    .dly_waddr (dly_waddr),
    .dly_wdata (dly_wdata),
    .dly_raddr (dly_raddr),
    .dly_rdata (dly_rdata)
  );

  dfir_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .tag  (tag),
    .x    (dly_rdata),
    .h    (tap_rdata),
    .done (mac_done),
    .res  (mac_res)
  );

endmodule

// ===== rtl/core/dfir_store.sv =====
// Coefficient memory and circular sample memory of the FIR filter.
// Depends on dfir_pkg. Both memories have one write and one registered read port.
`timescale 1ns / 1ps

module dfir_store
  import dfir_pkg::*;
(
  input  logic                     clk,
  input  logic                     tap_we,
  input  logic [TAP_AW-1:0]        tap_waddr,
  input  logic signed [COEF_W-1:0] tap_wdata,
  input  logic [TAP_AW-1:0]        tap_raddr,
  output logic signed [COEF_W-1:0] tap_rdata,
  input  logic                     dly_we,
  input  logic [TAP_AW-1:0]        dly_waddr,
  input  cpx_t                     dly_wdata,
  input  logic [TAP_AW-1:0]        dly_raddr,
  output cpx_t                     dly_rdata
);

  logic [COEF_W-1:0] tap_mem [MAX_TAPS];
  cpx_t              dly_mem [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    tap_rdata <= tap_mem[tap_raddr];
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_waddr] <= dly_wdata;
    end
    dly_rdata <= dly_mem[dly_raddr];
  end

endmodule

// ===== rtl/core/dfir_mac.sv =====
// Pipelined multiply-accumulate for the real and imaginary paths.
// Depends on dfir_pkg. Scales the sum by the coefficient fraction and saturates.
`timescale 1ns / 1ps

module dfir_mac
  import dfir_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_tag_t                 tag,
  input  cpx_t                     x,
  input  logic signed [COEF_W-1:0] h,
  output logic                     done,
  output cpx_t                     res
);

  localparam int SH_W = ACC_W - COEF_W + 1;
  localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_MIN = -SAT_MAX - SH_W'(1);

  mac_tag_t                  tag1, tag2, tag3;
  logic signed [PROD_W-1:0]  prod_re, prod_im;
  logic signed [ACC_W-1:0]   acc_re, acc_im;

  // Floor shift by the fraction bits, then clamp to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_scale(input logic signed [ACC_W-1:0] a);
    logic signed [SH_W-1:0] sh;
    sh = a[ACC_W-1:COEF_W-1];
    if (sh > SAT_MAX) begin
      return SAT_MAX[SAMPLE_W-1:0];
    end else if (sh < SAT_MIN) begin
      return SAT_MIN[SAMPLE_W-1:0];
    end
    return sh[SAMPLE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      done <= 1'b0;
    end else begin
      tag1 <= tag;
      tag2 <= tag1;
      tag3 <= tag2;
      done <= tag3.valid && tag3.last;
    end
  end

  always_ff @(posedge clk) begin
    // Samples older than anything written since reset count as zero.
    if (tag1.zero) begin
      prod_re <= '0;
      prod_im <= '0;
    end else begin
      prod_re <= x.re * h;
      prod_im <= x.im * h;
    end
    if (tag2.valid) begin
      if (tag2.first) begin
        acc_re <= ACC_W'(prod_re);
        acc_im <= ACC_W'(prod_im);
      end else begin
        acc_re <= acc_re + ACC_W'(prod_re);
        acc_im <= acc_im + ACC_W'(prod_im);
      end
    end
    if (tag3.valid && tag3.last) begin
      res.re <= sat_scale(acc_re);
      res.im <= sat_scale(acc_im);
    end
  end

endmodule

// ===== rtl/core/dfir_ctrl.sv =====
// Sequencer of the FIR filter: input decode, memory addressing and output register.
// Depends on dfir_pkg; drives dfir_store and dfir_mac.
`timescale 1ns / 1ps

module dfir_ctrl
  import dfir_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_W-1:0]     s_tdata,
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_W-1:0]    m_tdata,
  input  logic [CNT_W-1:0]         taps_eff,
  input  logic [TAP_AW-1:0]        skip_load,
  input  logic                     complex_mode,
  output logic                     tap_we,
  output logic [TAP_AW-1:0]        tap_waddr,
  output logic signed [COEF_W-1:0] tap_wdata,
  output logic [TAP_AW-1:0]        tap_raddr,
  output logic                     dly_we,
  output logic [TAP_AW-1:0]        dly_waddr,
  output cpx_t                     dly_wdata,
  output logic [TAP_AW-1:0]        dly_raddr,
  output mac_tag_t                 tag,
  input  logic                     mac_done,
  input  cpx_t                     mac_res
);

  ctrl_state_t       state, state_next;
  logic [TAP_AW-1:0] wptr;
  logic [CNT_W-1:0]  fill;
  logic [TAP_AW-1:0] skip;
  logic [TAP_AW-1:0] base;
  logic [TAP_AW-1:0] k;
  logic [CNT_W-1:0]  taps_lat;
  logic              load_out;

  assign tap_waddr      = s_tdata[IDX_LSB +: TAP_AW];
  assign tap_wdata      = s_tdata[VAL_LSB +: COEF_W];
  assign dly_waddr      = wptr;
  assign dly_wdata.re   = s_tdata[RE_LSB +: SAMPLE_W];
  assign dly_wdata.im   = complex_mode ? s_tdata[IM_LSB +: SAMPLE_W] : '0;
  assign tap_raddr      = k;
  assign dly_raddr      = base - k;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    tap_we     = 1'b0;
    dly_we     = 1'b0;
    tag        = '0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == OP_COEF) begin
            tap_we = 1'b1;
          end else begin
            dly_we = 1'b1;
            if (skip == '0) begin
              state_next = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        tag.valid = 1'b1;
        tag.first = (k == '0);
        tag.last  = ({1'b0, k} == taps_lat - CNT_W'(1));
        tag.zero  = ({1'b0, k} >= fill);
        if (tag.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wptr     <= '0;
      fill     <= '0;
      skip     <= '0;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (dly_we) begin
        wptr <= wptr + TAP_AW'(1);
        if (fill != CNT_W'(MAX_TAPS)) begin
          fill <= fill + CNT_W'(1);
        end
        k <= '0;
        if (skip != '0) begin
          skip <= skip - TAP_AW'(1);
        end else begin
          skip <= skip_load;
        end
      end else if (state == ST_READ) begin
        k <= k + TAP_AW'(1);
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      base     <= wptr;
      taps_lat <= taps_eff;
    end
    if (load_out) begin
      m_tdata <= {(complex_mode ? mac_res.im : {SAMPLE_W{1'b0}}), mac_res.re};
    end
  end

endmodule

// ===== rtl/core/dfir_chk.sv =====
// Port-level checker for the decimating FIR filter core, bound to the top level.
// Depends on dfir_pkg and decimating_fir_filter_core_defines.svh.
`timescale 1ns / 1ps
`include "decimating_fir_filter_core_defines.svh"

module dfir_chk
  import dfir_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // Shadow of the complex mode register, rebuilt from configuration transactions.
  logic cplx_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      cplx_seen <= 1'b0;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_COMPLEX) begin
      cplx_seen <= cfg_data[0];
    end
  end

  `DFIR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")
  `DFIR_ASSERT_IMP(a_real_im_zero, m_tvalid && !cplx_seen, m_tdata[OUT_DATA_W-1:SAMPLE_W] == '0, "nonzero imaginary output in real mode")
  `DFIR_ASSERT_NXT(a_coef_no_stall, s_tvalid && s_tready && s_tuser == OP_COEF, s_tready, "coefficient write stalled the input")
  `DFIR_ASSERT_ALW(a_rst_empty, $past(rst) == 1'b1, !m_tvalid, "output valid right after reset")

endmodule

bind decimating_fir_filter_core dfir_chk u_dfir_chk (.*);

// ===== verif/tb_decimating_fir_filter_core.sv =====
// Self-checking testbench for decimating_fir_filter_core: coefficient loads, decimation,
// complex mode and saturation, checked against a tap-by-tap filter model held here.
// Depends on dfir_pkg and the decimating_fir_filter_core RTL.
`timescale 1ns / 1ps

module tb_decimating_fir_filter_core;
  import dfir_pkg::*;

  localparam int    SETTLE_CYCLES = MAX_TAPS + 40;   // longer than one output computation
  localparam int    HOLD_CYCLES   = 400;             // long output back-pressure stretch
  localparam time   TIMEOUT_NS    = 64'd12_000_000;  // watchdog limit for the whole run
  localparam int    NUM_PHASES    = 11;

  // Scoreboard: keeps its own copy of the filter state and configuration, predicts
  // the output of every accepted sample and compares it with what leaves the block.
  class fir_scoreboard;
    cpx_t                       pending_outputs[$];
    int                         errors;
    logic [CFG_DATA_W-1:0]      taps_reg;
    logic [CFG_DATA_W-1:0]      decim_reg;
    logic                       complex_reg;
    logic signed [COEF_W-1:0]   coefs[MAX_TAPS];
    logic signed [SAMPLE_W-1:0] hist_re[MAX_TAPS-1];
    logic signed [SAMPLE_W-1:0] hist_im[MAX_TAPS-1];
    int                         skip_left;

    function new();
      errors      = 0;
      taps_reg    = NUM_TAPS_RST;
      decim_reg   = DECIMATION_RST;
      complex_reg = 1'b0;
      skip_left   = 0;
      foreach (coefs[i]) coefs[i] = '0;
      foreach (hist_re[i]) begin
        hist_re[i] = '0;
        hist_im[i] = '0;
      end
    endfunction

    task report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_NUM_TAPS:   taps_reg    = value;
        REG_DECIMATION: decim_reg   = value;
        REG_COMPLEX:    complex_reg = value[0];
        default: ;
      endcase
    endfunction

    // Floor shift by the coefficient fraction bits, then clamp to the sample range.
    function logic signed [SAMPLE_W-1:0] scale_saturate(input longint acc);
      longint scaled;
      scaled = acc >>> (COEF_W - 1);
      if (scaled > longint'(32767)) return 16'sh7FFF;
      if (scaled < longint'(-32768)) return 16'sh8000;
      return scaled[SAMPLE_W-1:0];
    endfunction

    function logic signed [SAMPLE_W-1:0] filter_sum(input logic signed [SAMPLE_W-1:0] newest,
                                                    input bit use_im, input int ntaps);
      longint acc;
      acc = longint'(newest) * longint'(coefs[0]);
      for (int k = 1; k < ntaps; k++)
        acc += longint'(use_im ? hist_im[k-1] : hist_re[k-1]) * longint'(coefs[k]);
      return scale_saturate(acc);
    endfunction

    function void note_input(input logic op, input logic [IN_DATA_W-1:0] data);
      int ntaps;
      int dec;
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      cpx_t out;
      if (op == OP_COEF) begin
        coefs[data[IDX_LSB +: TAP_AW]] = data[VAL_LSB +: COEF_W];
        return;
      end
      ntaps = int'(taps_reg);
      if (ntaps == 0) ntaps = 1;
      if (ntaps > MAX_TAPS) ntaps = MAX_TAPS;
      dec = int'(decim_reg);
      if (dec == 0) dec = 1;
      if (dec > ntaps) dec = ntaps;
      re = data[RE_LSB +: SAMPLE_W];
      im = complex_reg ? data[IM_LSB +: SAMPLE_W] : '0;
      if (skip_left != 0) begin
        skip_left--;
      end else begin
        out.re = filter_sum(re, 1'b0, ntaps);
        out.im = complex_reg ? filter_sum(im, 1'b1, ntaps) : '0;
        pending_outputs.push_back(out);
        skip_left = dec - 1;
      end
      for (int i = MAX_TAPS - 2; i > 0; i--) begin
        hist_re[i] = hist_re[i-1];
        hist_im[i] = hist_im[i-1];
      end
      hist_re[0] = re;
      hist_im[0] = im;
    endfunction

    task check_result(input logic [OUT_DATA_W-1:0] data);
      cpx_t got;
      cpx_t want;
      got = data;
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("output %h arrived with nothing expected", data));
        return;
      end
      want = pending_outputs.pop_front();
      if (got.re !== want.re)
        report_mismatch($sformatf("result_re got %0d expected %0d", got.re, want.re));
      if (got.im !== want.im)
        report_mismatch($sformatf("result_im got %0d expected %0d", got.im, want.im));
    endtask

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  // [15:0] sample_re, [31:16] sample_im, [37:32] coef_index, [53:38] coef_value,
  // [55:54] zero
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  // [0] op
  logic                  s_tuser   = OP_SAMPLE;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // [15:0] result_re, [31:16] result_im
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_NUM_TAPS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  fir_scoreboard sb = new();
  int            burst_left  = 0;
  int            holds_asked = 0;

  // Settings walked by the random part: taps, decimation and complex mode, including
  // zero and over-range register values that the block must clamp.
  int unsigned ph_taps [NUM_PHASES] = '{64, 64,  1, 1, 0, 127,  17, 8, 33, 5, 64};
  int unsigned ph_dec  [NUM_PHASES] = '{1,  64,  1, 5, 0,   3, 127, 1,  7, 2,  2};
  int unsigned ph_cpx  [NUM_PHASES] = '{0,   1,  1, 0, 1,   1,   0, 1,  0, 1,  0};
  int unsigned ph_items[NUM_PHASES] = '{90, 150, 60, 60, 60, 90, 120, 90, 90, 80, 60};

  decimating_fir_filter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Monitors sample the pre-edge values, which are the ones the block acted on.
  // Predictions are made at the moment an input transaction is accepted, with the
  // configuration that is in force at that time.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // Extremes and small values are favored so that both saturation and plain
  // in-range sums show up often.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4, 5:    return 16'($urandom_range(0, 4095)) - 16'd2048;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(input logic [15:0] re, input logic [15:0] im,
                                                     input logic [5:0] idx,
                                                     input logic [15:0] value);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[RE_LSB  +: SAMPLE_W] = re;
    d[IM_LSB  +: SAMPLE_W] = im;
    d[IDX_LSB +: TAP_AW]   = idx;
    d[VAL_LSB +: COEF_W]   = value;
    return d;
  endfunction

  // Offers one item and waits for its transaction. Valid stays high across a burst;
  // at the end of a burst it drops for a random gap, sometimes of zero length.
  task automatic offer(input logic op, input logic [IN_DATA_W-1:0] data);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // The unused fields of each item carry random bits; the block must ignore them.
  task automatic send_sample(input logic [15:0] re, input logic [15:0] im);
    offer(OP_SAMPLE, pack_item(re, im, 6'($urandom), 16'($urandom)));
  endtask

  task automatic send_coef(input logic [5:0] idx, input logic [15:0] value);
    offer(OP_COEF, pack_item(16'($urandom), 16'($urandom), idx, value));
  endtask

  // Stops offering, waits for every predicted output, then lets a full output
  // computation's worth of cycles pass so the block is idle before reconfiguring.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_filter(input int unsigned ntaps, input int unsigned dec,
                                input int unsigned cpx);
    cfg_idx_t              idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    idx[0] = REG_NUM_TAPS;   val[0] = CFG_DATA_W'(ntaps);
    idx[1] = REG_DECIMATION; val[1] = CFG_DATA_W'(dec);
    idx[2] = REG_COMPLEX;    val[2] = {6'($urandom), 1'(cpx)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) send_coef(6'($urandom), pick_word());
      else send_sample(pick_word(), pick_word());
    end
  endtask

  // Output side: changes its stall behavior every so often, and on request holds
  // off for a long stretch so the output register fills and the input stalls.
  initial begin : receiver
    int mode;
    int span;
    int tick;
    int holds_given;
    tick = 0;
    holds_given = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (holds_given < holds_asked) begin
          holds_given++;
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= tick[2];
        endcase
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every tap gets a value before the first sample, so no unwritten tap is read.
    for (int k = 0; k < MAX_TAPS; k++) send_coef(6'(k), pick_word());
    wait_drained();

    // Directed part on a two-tap complex filter.
    program_filter(2, 1, 1);
    // Most negative taps: most negative samples push the sum past the positive
    // limit, most positive ones past the negative limit.
    send_coef(6'd0, 16'h8000);
    send_coef(6'd1, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h7FFF, 16'h8000);
    // A unit tap shows the shift rounding toward minus infinity.
    send_coef(6'd0, 16'h0001);
    send_coef(6'd1, 16'h0000);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'h0000, 16'h0000);
    // Most positive taps with mixed extreme samples.
    send_coef(6'd0, 16'h7FFF);
    send_coef(6'd1, 16'h7FFF);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'hFFFF);
    send_sample(16'h0001, 16'h0000);
    // Top tap index, outside the taps in use, then a sample that must not see it.
    send_coef(6'd63, 16'h7FFF);
    send_sample(16'h4000, 16'hC000);
    send_sample(16'hFFFF, 16'hFFFF);
    wait_drained();

    for (int p = 0; p < NUM_PHASES + 2; p++) begin
      if (p < NUM_PHASES) program_filter(ph_taps[p], ph_dec[p], ph_cpx[p]);
      else program_filter($urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 1));
      // Short filter at full rate: the long hold backs results up into the input.
      if (p == 7) holds_asked++;
      run_random((p < NUM_PHASES) ? int'(ph_items[p]) : 60);
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
